### rtl/core/rfd_pkg.sv
// Package for the rotation and flow detector core.
// Holds shared widths, the sequencer state type and the register index codes.
// No dependencies.
package rfd_pkg;

  localparam int unsigned WinDepth     = 256;
  localparam int unsigned WinAw        = $clog2(WinDepth);
  localparam int unsigned MaxRotWindow = 1024;

  localparam int unsigned MagW    = 20;  // |g| with four fraction bits
  localparam int unsigned TimeW   = 48;
  localparam int unsigned SumW    = 28;
  localparam int unsigned SqSumW  = 48;
  localparam int unsigned DvdW    = 57;  // n * sum of squares
  localparam int unsigned DvsW    = 17;  // n * n
  localparam int unsigned DivCntW = $clog2(DvdW);

  localparam logic [TimeW-1:0] Max48 = {TimeW{1'b1}};

  typedef enum logic [2:0] {
    REG_ROT_MIN_AMP   = 3'd0,
    REG_ROT_WIN_CNT   = 3'd1,
    REG_ROT_MIN_CROSS = 3'd2,
    REG_FLOW_WIN_US   = 3'd3,
    REG_FLOW_HIGH     = 3'd4,
    REG_FLOW_LOW      = 3'd5,
    REG_FLOW_ON_HOLD  = 3'd6,
    REG_FLOW_OFF_HOLD = 3'd7
  } rfd_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_FULL_RD,
    ST_FULL_DROP,
    ST_INSERT,
    ST_EVICT_RD,
    ST_EVICT_CHK,
    ST_VAR_A0,
    ST_VAR_A1,
    ST_VAR_B,
    ST_VAR_N,
    ST_DIV,
    ST_HOLD,
    ST_FIN
  } rfd_state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } rfd_div_ctl_t;

endpackage

### rtl/core/rotation_and_flow_detector_core.sv
// Top level of the rotation and flow detector.
// Depends on rfd_pkg and rfd_divider.
//
// One sensor sample (magnetometer x/y, accelerometer x/y/z, 48-bit microsecond
// timestamp) enters as one slave stream transfer and yields exactly one master
// stream transfer with the rotation flag, the flow flag and the windowed
// variance of the accelerometer magnitude. The user must write configuration registers
// through the plain write port while no sample is in flight; the core does not enforce it.
// Steps from the accepting edge to tvalid: the squares of x, y and z on the shared
// multiplier, the serial square root, storing the sample and checking the oldest
// entry (a full window drops its oldest entry first), an eviction check for each
// entry evicted by age, the variance multiplies and the divider, then the hold
// logic and hand-off. One sample
// is processed at a time and tready is high only while the sequencer is idle;
// the serial divider dominates. A finished result sits in an output register
// and the next sample may be taken while it waits; if the receiver stalls, that
// sample runs up to the result stage and waits there. Reset clears counters,
// sums, hold timers and flags and loads the register reset values; the window
// memory is not cleared because only entries below the fill count are read.
module rotation_and_flow_detector_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  // mag_x[15:0], mag_y[31:16], acc_x[47:32], acc_y[63:48], acc_z[79:64],
  // timestamp_us[127:80]
  input  logic [127:0]  s_axis_tdata_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // rotation_flag[0], flow_flag[1], flow_variance[49:2], zero fill above
  output logic [55:0]   m_axis_tdata_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [47:0]   cfg_wdata_i
);
  import rfd_pkg::*;

  // Configuration registers.
  logic [14:0] rot_min_amp_q;
  logic [10:0] rot_win_cnt_q;
  logic [11:0] rot_min_cross_q;
  logic [31:0] flow_win_us_q, flow_on_hold_q, flow_off_hold_q;
  logic [47:0] flow_high_q, flow_low_q;

  // Sequencer and state.
  rfd_state_e        state_q, state_d;
  logic [10:0]       sample_cnt_q;
  logic [11:0]       cross_cnt_q;
  logic [1:0]        sign_x_q, sign_y_q;
  logic              rot_q, flow_q;
  logic [WinAw-1:0]  head_q;
  logic [WinAw:0]    fill_q;
  logic [SumW-1:0]   sum_q;
  logic [SqSumW-1:0] sqsum_q;
  logic [TimeW-1:0]  prev_time_q, on_hold_q, off_hold_q, dt_q;
  logic              out_valid_q;
  logic              out_rot_q, out_flow_q;
  logic [TimeW-1:0]  out_var_q;

  // Per-sample working registers.
  logic [16:0]       abs_x_q, abs_y_q, abs_z_q;
  logic [TimeW-1:0]  t_q;
  logic [41:0]       rad_q;
  logic [23:0]       srem_q;
  logic [20:0]       root_q;
  logic [4:0]        scnt_q;
  logic [DvdW-1:0]   a_q;
  logic [DvdW-2:0]   b_q;
  logic [TimeW-1:0]  var_q;

  // Window memory: {time, magnitude} per entry.
  logic [TimeW+MagW-1:0] win_mem [WinDepth];
  logic [TimeW+MagW-1:0] rd_q;
  logic [WinAw-1:0]      tail;
  logic [MagW-1:0]       rd_mag, g_val;
  logic [TimeW-1:0]      rd_time, age;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Divider hookup.
  rfd_div_ctl_t    div_ctl;
  logic            div_start;
  logic [DvdW-1:0] div_dvd, div_q;

  // Input fields.
  logic signed [15:0] in_mag_x, in_mag_y, in_acc_x, in_acc_y, in_acc_z;
  logic [TimeW-1:0]   in_ts;
  logic               in_fire;

  assign in_mag_x = s_axis_tdata_i[15:0];
  assign in_mag_y = s_axis_tdata_i[31:16];
  assign in_acc_x = s_axis_tdata_i[47:32];
  assign in_acc_y = s_axis_tdata_i[63:48];
  assign in_acc_z = s_axis_tdata_i[79:64];
  assign in_ts    = s_axis_tdata_i[127:80];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_mag  = rd_q[MagW-1:0];
  assign rd_time = rd_q[TimeW+MagW-1:MagW];
  assign age     = t_q - rd_time;
  assign tail    = head_q + fill_q[WinAw-1:0];
  assign g_val   = root_q[MagW-1:0];

  function automatic logic [16:0] abs16(logic [15:0] v);
    abs16 = v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  // Amplitude-gated sign: 0 zero, 1 positive, 2 negative.
  function automatic logic [1:0] gate_sign(logic [15:0] v, logic [14:0] min_amp);
    logic [16:0] m;
    m = abs16(v);
    if (v == '0 || m < {2'b0, min_amp}) gate_sign = 2'd0;
    else gate_sign = v[15] ? 2'd2 : 2'd1;
  endfunction

  // Rotation update, done in the accept cycle.
  logic [1:0]  sx, sy;
  logic [10:0] rot_w, sc_new;
  logic [12:0] cc_sum, cc_cap;
  logic [11:0] cc_new;

  always_comb begin
    sx = gate_sign(in_mag_x, rot_min_amp_q);
    sy = gate_sign(in_mag_y, rot_min_amp_q);
    if (rot_win_cnt_q == '0) rot_w = 11'd1;
    else if (rot_win_cnt_q > 11'(MaxRotWindow)) rot_w = 11'(MaxRotWindow);
    else rot_w = rot_win_cnt_q;
    sc_new = (sample_cnt_q < rot_w) ? sample_cnt_q + 1'b1 : sample_cnt_q;
    cc_sum = {1'b0, cross_cnt_q}
           + 13'((sign_x_q != 2'd0 && sx != 2'd0 && sx != sign_x_q) ? 1 : 0)
           + 13'((sign_y_q != 2'd0 && sy != 2'd0 && sy != sign_y_q) ? 1 : 0);
    cc_cap = {1'b0, rot_w, 1'b0};
    if (sc_new > 11'd1) cc_new = (cc_sum > cc_cap) ? cc_cap[11:0] : cc_sum[11:0];
    else cc_new = cross_cnt_q;
  end

  // Elapsed time since the previous sample.
  logic [TimeW-1:0] prev_eff, dt_new;
  always_comb begin
    prev_eff = (prev_time_q == '0) ? in_ts : prev_time_q;
    dt_new   = (in_ts >= prev_eff) ? in_ts - prev_eff : '0;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ_X:                   begin mul_a = 32'(abs_x_q); mul_b = 32'(abs_x_q); end
      ST_SQ_Y:                   begin mul_a = 32'(abs_y_q); mul_b = 32'(abs_y_q); end
      ST_SQ_Z:                   begin mul_a = 32'(abs_z_q); mul_b = 32'(abs_z_q); end
      ST_FULL_DROP, ST_EVICT_CHK: begin mul_a = 32'(rd_mag); mul_b = 32'(rd_mag); end
      ST_INSERT:                 begin mul_a = 32'(g_val); mul_b = 32'(g_val); end
      ST_VAR_A0:                 begin mul_a = 32'(fill_q); mul_b = sqsum_q[31:0]; end
      ST_VAR_A1:                 begin mul_a = 32'(fill_q); mul_b = 32'(sqsum_q[47:32]); end
      ST_VAR_B:                  begin mul_a = 32'(sum_q); mul_b = 32'(sum_q); end
      ST_VAR_N:                  begin mul_a = 32'(fill_q); mul_b = 32'(fill_q); end
      default:                   begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Square root step.
  logic [23:0] s_shift;
  logic [22:0] s_trial;
  assign s_shift = {srem_q[21:0], rad_q[41:40]};
  assign s_trial = {root_q, 2'b01};

  logic evict_now;
  assign evict_now = ({16'b0, flow_win_us_q} < age);

  assign div_start = (state_q == ST_VAR_N);
  assign div_dvd   = (a_q > {1'b0, b_q}) ? a_q - {1'b0, b_q} : '0;

  rfd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (mul_p[DvsW-1:0]),
    .ctl_o      (div_ctl),
    .quotient_o (div_q)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_SQ_X;
      ST_SQ_X:      state_d = ST_SQ_Y;
      ST_SQ_Y:      state_d = ST_SQ_Z;
      ST_SQ_Z:      state_d = ST_SQRT;
      ST_SQRT:      if (scnt_q == '0) state_d = fill_q[WinAw] ? ST_FULL_RD : ST_INSERT;
      ST_FULL_RD:   state_d = ST_FULL_DROP;
      ST_FULL_DROP: state_d = ST_INSERT;
      ST_INSERT:    state_d = ST_EVICT_RD;
      ST_EVICT_RD:  state_d = (fill_q > (WinAw+1)'(1)) ? ST_EVICT_CHK : ST_VAR_A0;
      ST_EVICT_CHK: state_d = evict_now ? ST_EVICT_RD : ST_VAR_A0;
      ST_VAR_A0:    state_d = ST_VAR_A1;
      ST_VAR_A1:    state_d = ST_VAR_B;
      ST_VAR_B:     state_d = ST_VAR_N;
      ST_VAR_N:     state_d = ST_DIV;
      ST_DIV:       if (div_ctl.done) state_d = ST_HOLD;
      ST_HOLD:      state_d = ST_FIN;
      ST_FIN:       if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Hold timer update.
  logic [TimeW:0]   on_add, off_add;
  logic [TimeW-1:0] on_sat, off_sat, on_n, off_n;
  logic             flow_n;
  always_comb begin
    on_add  = {1'b0, on_hold_q} + {1'b0, dt_q};
    off_add = {1'b0, off_hold_q} + {1'b0, dt_q};
    on_sat  = on_add[TimeW] ? Max48 : on_add[TimeW-1:0];
    off_sat = off_add[TimeW] ? Max48 : off_add[TimeW-1:0];
    priority if (var_q > flow_high_q) begin
      on_n = on_sat; off_n = '0;
    end else if (var_q < flow_low_q) begin
      on_n = '0; off_n = off_sat;
    end else begin
      on_n = '0; off_n = '0;
    end
    flow_n = flow_q;
    if (!flow_q && on_n >= {16'b0, flow_on_hold_q}) begin
      flow_n = 1'b1;
      on_n   = '0;
    end else if (flow_q && off_n >= {16'b0, flow_off_hold_q}) begin
      flow_n = 1'b0;
      off_n  = '0;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      rot_min_amp_q   <= '0;
      rot_win_cnt_q   <= 11'd1;
      rot_min_cross_q <= '0;
      flow_win_us_q   <= 32'd1000000;
      flow_high_q     <= '0;
      flow_low_q      <= '0;
      flow_on_hold_q  <= '0;
      flow_off_hold_q <= '0;
      sample_cnt_q    <= '0;
      cross_cnt_q     <= '0;
      sign_x_q        <= '0;
      sign_y_q        <= '0;
      rot_q           <= 1'b0;
      flow_q          <= 1'b0;
      head_q          <= '0;
      fill_q          <= '0;
      sum_q           <= '0;
      sqsum_q         <= '0;
      prev_time_q     <= '0;
      on_hold_q       <= '0;
      off_hold_q      <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (rfd_reg_e'(cfg_idx_i))
          REG_ROT_MIN_AMP:   rot_min_amp_q   <= cfg_wdata_i[14:0];
          REG_ROT_WIN_CNT:   rot_win_cnt_q   <= cfg_wdata_i[10:0];
          REG_ROT_MIN_CROSS: rot_min_cross_q <= cfg_wdata_i[11:0];
          REG_FLOW_WIN_US:   flow_win_us_q   <= cfg_wdata_i[31:0];
          REG_FLOW_HIGH:     flow_high_q     <= cfg_wdata_i;
          REG_FLOW_LOW:      flow_low_q      <= cfg_wdata_i;
          REG_FLOW_ON_HOLD:  flow_on_hold_q  <= cfg_wdata_i[31:0];
          REG_FLOW_OFF_HOLD: flow_off_hold_q <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      // A new result loads when the register is free or drains in this cycle;
      // otherwise a waiting result stays until its transfer.
      out_valid_q <= (state_q == ST_FIN && (!out_valid_q || m_axis_tready_i)) ||
                     (out_valid_q && !m_axis_tready_i);
      unique case (state_q)
        ST_IDLE: if (in_fire) begin
          sample_cnt_q <= sc_new;
          cross_cnt_q  <= cc_new;
          if (sx != 2'd0) sign_x_q <= sx;
          if (sy != 2'd0) sign_y_q <= sy;
          rot_q        <= (sc_new >= rot_w) && (cc_new >= rot_min_cross_q);
          prev_time_q  <= in_ts;
        end
        ST_FULL_DROP, ST_EVICT_CHK: begin
          if (state_q == ST_FULL_DROP || evict_now) begin
            sum_q   <= sum_q - SumW'(rd_mag);
            sqsum_q <= sqsum_q - mul_p[SqSumW-1:0];
            head_q  <= head_q + 1'b1;
            fill_q  <= fill_q - 1'b1;
          end
        end
        ST_INSERT: begin
          sum_q   <= sum_q + SumW'(g_val);
          sqsum_q <= sqsum_q + mul_p[SqSumW-1:0];
          fill_q  <= fill_q + 1'b1;
        end
        ST_HOLD: begin
          on_hold_q  <= on_n;
          off_hold_q <= off_n;
          flow_q     <= flow_n;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (in_fire) begin
        abs_x_q <= abs16(in_acc_x);
        abs_y_q <= abs16(in_acc_y);
        abs_z_q <= abs16(in_acc_z);
        t_q     <= in_ts;
        dt_q    <= dt_new;
        a_q     <= '0;
      end
      ST_SQ_X, ST_SQ_Y: a_q <= a_q + DvdW'(mul_p);
      ST_SQ_Z: begin
        // Radicand is the sum of squares times 256, taken two bits a step.
        rad_q  <= {a_q[33:0] + mul_p[33:0], 8'b0};
        srem_q <= '0;
        root_q <= '0;
        scnt_q <= 5'd20;
      end
      ST_SQRT: begin
        if ({1'b0, s_trial} <= s_shift) begin
          srem_q <= s_shift - {1'b0, s_trial};
          root_q <= {root_q[19:0], 1'b1};
        end else begin
          srem_q <= s_shift;
          root_q <= {root_q[19:0], 1'b0};
        end
        rad_q  <= {rad_q[39:0], 2'b00};
        scnt_q <= scnt_q - 1'b1;
      end
      ST_VAR_A0: a_q <= DvdW'(mul_p[40:0]);
      ST_VAR_A1: a_q <= a_q + {mul_p[24:0], 32'b0};
      ST_VAR_B:  b_q <= mul_p[DvdW-2:0];
      ST_DIV: if (div_ctl.done) begin
        var_q <= (div_q > DvdW'(Max48)) ? Max48 : div_q[TimeW-1:0];
      end
      ST_FIN: if (!out_valid_q || m_axis_tready_i) begin
        out_rot_q  <= rot_q;
        out_flow_q <= flow_q;
        out_var_q  <= var_q;
      end
      default: ;
    endcase
  end

  // Window memory.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_INSERT) win_mem[tail] <= {t_q, g_val};
    rd_q <= win_mem[head_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_var_q, out_flow_q, out_rot_q};

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (WinAw+1)'(WinDepth))
    else $error("window fill count beyond depth");

  a_evict_keeps_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVICT_CHK |-> fill_q > (WinAw+1)'(1))
    else $error("eviction check with a single entry");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.busy |-> state_q == ST_DIV)
    else $error("divider running outside the divide step");

  a_cross_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cross_cnt_q <= 12'(2 * MaxRotWindow))
    else $error("crossing count above its cap");
`endif

endmodule

### rtl/core/rfd_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rfd_pkg for the operand widths.
module rfd_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rfd_pkg::DvdW-1:0]   dividend_i,
  input  logic [rfd_pkg::DvsW-1:0]   divisor_i,
  output rfd_pkg::rfd_div_ctl_t      ctl_o,
  output logic [rfd_pkg::DvdW-1:0]   quotient_o
);
  import rfd_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0]    dq_q, dq_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dq_q[DvdW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DvdW - 1);
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // Shift in the next dividend bit and try to take the divisor away.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DvsW'(trial - {1'b0, dvs_q});
        dq_d  = {dq_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[DvsW-1:0];
        dq_d  = {dq_q[DvdW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
  assign quotient_o  = dq_q;

endmodule
